// File: rtl/core/rans_enc_pkg.sv
// Shared types and constants for the rANS byte encoder.
`default_nettype none

package rans_enc_pkg;

    // Fixed field widths of the transfer payloads.
    localparam int OPCODE_W = 2;
    localparam int SYMBOL_W = 8;
    localparam int FREQ_W   = 13;
    localparam int BYTE_W   = 8;
    localparam int TABLE_DEPTH = 1 << SYMBOL_W;
    localparam int FLUSH_BYTES = 8;
    localparam int FLUSH_CNT_W = 3;

    // Opcodes of an input item.
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [SYMBOL_W-1:0] symbol;
        logic [FREQ_W-1:0]   freq_value;
        logic [FREQ_W-1:0]   cum_value;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_error;
        logic              last;
    } t_out_item;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RENORM,
        S_DIV_START,
        S_DIV_WAIT,
        S_ERROR,
        S_FLUSH
    } t_seq_state;

endpackage

`default_nettype wire

// File: rtl/core/rans_enc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module rans_enc_div #(
    parameter int DividendW = 36
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [DividendW-1:0]                i_dividend,
    input  wire logic [rans_enc_pkg::FREQ_W-1:0]     i_divisor,
    output logic                                     o_done,
    output logic      [DividendW-1:0]                o_quotient,
    output logic      [rans_enc_pkg::FREQ_W-1:0]     o_remainder
);
    import rans_enc_pkg::*;

    localparam int CntW = $clog2(DividendW + 1);

    logic [DividendW-1:0] r_quo;
    logic [FREQ_W-1:0]    r_rem;
    logic [FREQ_W-1:0]    r_div;
    logic [CntW-1:0]      r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [FREQ_W:0]      trial;
    logic                 fits;
    logic [FREQ_W:0]      diff;

    // One step: bring down the next dividend bit and try a subtraction.
    always_comb begin
        trial = {r_rem, r_quo[DividendW-1]};
        fits  = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
    end

    // Control: busy until every dividend bit has been shifted through, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(DividendW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CntW'(1);
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in from the right as the dividend leaves.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DividendW-2:0], fits};
            r_rem <= fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// File: rtl/core/rans_byte_encoder_top.sv
// Top level of the rANS byte encoder: symbol tables, sequencer and coder state.
`default_nettype none

// rANS encoder with byte renormalization. A load item (opcode 0) writes one
// symbol's frequency and cumulative start, and the block is ready again in
// the cycle after. An encode item (opcode 1, symbols given in reverse order)
// emits one result per low byte shifted out during renormalization, then
// updates the coder state through a restoring divider that produces one
// quotient bit per cycle. A zero-frequency symbol gives a single error result
// and leaves the state alone. A flush item (opcode 2) emits the state as
// eight bytes, low byte first, and returns the state to its lower bound.
// Opcode 3 is dropped. Tables read as zero until written; no item is
// accepted while another is still in progress.
module rans_byte_encoder_top #(
    parameter int PROB_BITS = 12,
    parameter int LOW_SHIFT = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire rans_enc_pkg::t_in_item   i_in_item,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output rans_enc_pkg::t_out_item       o_out_item
);
    import rans_enc_pkg::*;

    localparam int StateW   = LOW_SHIFT + PROB_BITS + 8;
    localparam int CmpW     = StateW + FREQ_W;
    localparam int BoundSh  = LOW_SHIFT + 8;
    localparam logic [StateW-1:0] StateInit = StateW'(1) << (LOW_SHIFT + PROB_BITS);

    t_seq_state r_seq;
    t_seq_state n_seq;

    logic [StateW-1:0]      r_state;
    logic [FLUSH_CNT_W-1:0] r_fcnt;
    logic [2*FREQ_W-1:0]    r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_tab_valid;
    logic [2*FREQ_W-1:0]    r_rd_data;
    logic                   r_rd_valid;

    logic                   in_xfer;
    logic                   out_xfer;
    logic [FREQ_W-1:0]      freq;
    logic [FREQ_W-1:0]      cum;
    logic [CmpW-1:0]        bound;
    logic                   state_gt;
    logic                   shifted_gt;
    logic                   div_start;
    logic                   div_done;
    logic [StateW-1:0]      div_quo;
    logic [FREQ_W-1:0]      div_rem;
    logic [StateW-1:0]      coded;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    // Table memory: written on a load transfer, read on every input transfer.
    always_ff @(posedge i_clk) begin
        if (in_xfer && (i_in_item.opcode == OP_LOAD)) begin
            r_mem[i_in_item.symbol] <= {i_in_item.freq_value, i_in_item.cum_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rd_data <= r_mem[i_in_item.symbol];
        end
    end

    // Per-entry valid bits stand in for clearing the tables at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else if (in_xfer) begin
            r_rd_valid <= r_tab_valid[i_in_item.symbol];
            if (i_in_item.opcode == OP_LOAD) begin
                r_tab_valid[i_in_item.symbol] <= 1'b1;
            end
        end
    end

    assign freq = r_rd_valid ? r_rd_data[2*FREQ_W-1:FREQ_W] : '0;
    assign cum  = r_rd_valid ? r_rd_data[FREQ_W-1:0] : '0;

    // Renormalization compares against freq << (LOW_SHIFT + 8).
    always_comb begin
        bound      = CmpW'(freq) << BoundSh;
        state_gt   = CmpW'(r_state) > bound;
        shifted_gt = CmpW'(r_state >> 8) > bound;
    end

    // Divider computes state / freq and state % freq.
    rans_enc_div #(
        .DividendW (StateW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_state),
        .i_divisor   (freq),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // New state: (quotient << PROB_BITS) + cum + remainder, wrapped to width.
    assign coded = {div_quo[StateW-PROB_BITS-1:0], {PROB_BITS{1'b0}}}
                 + StateW'(cum) + StateW'(div_rem);

    // Next-state logic of the sequencer.
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in_item.opcode == OP_ENCODE) begin
                        n_seq = S_CHECK;
                    end else if (i_in_item.opcode == OP_FLUSH) begin
                        n_seq = S_FLUSH;
                    end
                end
            end
            S_CHECK: begin
                if (freq == '0) begin
                    n_seq = S_ERROR;
                end else if (state_gt) begin
                    n_seq = S_RENORM;
                end else begin
                    n_seq = S_DIV_START;
                end
            end
            S_RENORM: begin
                if (i_out_ready && !shifted_gt) begin
                    n_seq = S_DIV_START;
                end
            end
            S_DIV_START: begin
                n_seq = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_seq = S_IDLE;
                end
            end
            S_ERROR: begin
                if (i_out_ready) begin
                    n_seq = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_out_ready && (r_fcnt == FLUSH_CNT_W'(FLUSH_BYTES - 1))) begin
                    n_seq = S_IDLE;
                end
            end
            default: begin
                n_seq = S_IDLE;
            end
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_item  = '0;
        div_start   = 1'b0;
        unique case (r_seq)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_RENORM: begin
                o_out_valid         = 1'b1;
                o_out_item.out_byte = r_state[BYTE_W-1:0];
                o_out_item.last     = !shifted_gt;
            end
            S_DIV_START: begin
                div_start = 1'b1;
            end
            S_ERROR: begin
                o_out_valid         = 1'b1;
                o_out_item.is_error = 1'b1;
                o_out_item.last     = 1'b1;
            end
            S_FLUSH: begin
                o_out_valid         = 1'b1;
                o_out_item.out_byte = r_state[BYTE_W-1:0];
                o_out_item.last     = (r_fcnt == FLUSH_CNT_W'(FLUSH_BYTES - 1));
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= S_IDLE;
        end else begin
            r_seq <= n_seq;
        end
    end

    // Coder state and flush byte counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StateInit;
            r_fcnt  <= '0;
        end else begin
            if (in_xfer) begin
                r_fcnt <= '0;
            end
            if (r_seq == S_RENORM && out_xfer) begin
                r_state <= r_state >> 8;
            end else if (r_seq == S_DIV_WAIT && div_done) begin
                r_state <= coded;
            end else if (r_seq == S_FLUSH && out_xfer) begin
                r_fcnt <= r_fcnt + FLUSH_CNT_W'(1);
                if (r_fcnt == FLUSH_CNT_W'(FLUSH_BYTES - 1)) begin
                    r_state <= StateInit;
                end else begin
                    r_state <= r_state >> 8;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rans_enc_checker.sv
// Port-level checker for the rANS byte encoder and its bind to the top level.
`default_nettype none

module rans_enc_props (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    i_in_ready,
    input wire rans_enc_pkg::t_in_item  i_in_item,
    input wire logic                    i_out_valid,
    input wire logic                    i_out_ready,
    input wire rans_enc_pkg::t_out_item i_out_item
);
    import rans_enc_pkg::*;

    // The block never takes a new item while a result is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while a result is pending");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_item)))
        else $error("result changed while stalled");

    // An error result carries no byte and closes its item.
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_item.is_error) |->
            (i_out_item.last && (i_out_item.out_byte == '0)))
        else $error("malformed error result");

    // A load leaves the block ready again in the next cycle.
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_item.opcode == OP_LOAD)) |=> i_in_ready)
        else $error("load did not return to ready");

    // Nothing follows the last result of an item.
    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_item.last) |=> !i_out_valid)
        else $error("result after last transfer");

endmodule

bind rans_byte_encoder_top rans_enc_props u_rans_enc_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

`default_nettype wire
